>>> rtl/bts_pkg.sv
// Shared types and constants for the bilinear texture sampler.
// No dependencies; every other file of the block imports this package.
package bts_pkg;

    // fixed field widths
    localparam int SIZE_W     = 13;
    localparam int COORD_IN_W = 16;
    localparam int ADDR_IN_W  = 16;
    localparam int TEXEL_W    = 32;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 4;
    localparam int OUT_W      = 16;
    localparam int IDX_W      = SIZE_W + 1;
    localparam int CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_PITCH  = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd256;

    // item kinds
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // corner sequence and result queue
    localparam logic [1:0] CORNER_LAST = 2'd3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // control that travels with every memory slot
    typedef struct packed {
        logic valid;
        logic wr;
        logic first;
        logic last;
    } slot_ctl_t;

endpackage

>>> rtl/bts_coord_split.sv
// Coordinate split: scales a fraction to texel space and returns floor and weight.
// Depends on bts_pkg.
module bts_coord_split import bts_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int WT_BITS   = 8
) (
    input  logic [FRAC_BITS-1:0]    frac,
    input  logic [SIZE_W-1:0]       size,
    output logic signed [IDX_W-1:0] idx,
    output logic [WT_BITS-1:0]      wt
);
    localparam int T_W = FRAC_BITS + SIZE_W;
    localparam int E_W = FRAC_BITS + WT_BITS;

    logic [T_W-1:0]    prod;
    logic [T_W-1:0]    t_val;
    logic [SIZE_W-1:0] whole;
    logic [E_W-1:0]    ext;

    // t = f*size + half, so the floor index is (t >> F) - 1
    assign prod  = T_W'(frac) * T_W'(size);
    assign t_val = prod + (T_W'(1) << (FRAC_BITS - 1));
    assign whole = t_val[T_W-1 -: SIZE_W];
    assign idx   = $signed({1'b0, whole}) - IDX_W'(1);

    // align the fraction to the weight width, truncating or padding
    assign ext = {t_val[FRAC_BITS-1:0], {WT_BITS{1'b0}}};
    assign wt  = ext[E_W-1 -: WT_BITS];

endmodule

>>> rtl/bts_addr_unit.sv
// Address pipeline: linear texel address, modulo the store size, corner weight.
// Depends on bts_pkg; the modulo uses a reciprocal multiply and one correction.
module bts_addr_unit import bts_pkg::*; #(
    parameter int STORE_WORDS = 65536,
    parameter int WEIGHT_BITS = 8,
    localparam int AW = $clog2(STORE_WORDS),
    localparam int CW = 2 * WEIGHT_BITS + 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  slot_ctl_t            in_ctl,
    input  logic [SIZE_W-1:0]    in_cx,
    input  logic [SIZE_W-1:0]    in_cy,
    input  logic [ADDR_IN_W-1:0] in_waddr,
    input  logic [TEXEL_W-1:0]   in_wdata,
    input  logic [WEIGHT_BITS:0] in_wx,
    input  logic [WEIGHT_BITS:0] in_wy,
    input  logic [SIZE_W-1:0]    row_pitch,
    output slot_ctl_t            mem_ctl,
    output logic [AW-1:0]        mem_addr,
    output logic [TEXEL_W-1:0]   mem_wdata,
    output logic [CW-1:0]        mem_cw
);
    localparam int LW  = 2 * SIZE_W + 1;
    localparam int LW2 = 2 * LW;
    localparam int CWF = 2 * WEIGHT_BITS + 2;
    localparam logic [LW-1:0] MOD   = LW'(STORE_WORDS);
    localparam logic [LW-1:0] RECIP = LW'((64'd1 << LW) / STORE_WORDS);

    // stage 1: corner coordinates
    slot_ctl_t            s1_ctl_reg;
    logic [SIZE_W-1:0]    s1_cx_reg, s1_cy_reg;
    logic [ADDR_IN_W-1:0] s1_waddr_reg;
    logic [TEXEL_W-1:0]   s1_wdata_reg;
    logic [WEIGHT_BITS:0] s1_wx_reg, s1_wy_reg;

    // stage 2: linear address and corner weight
    slot_ctl_t          s2_ctl_reg;
    logic [LW-1:0]      s2_lin_reg;
    logic [TEXEL_W-1:0] s2_wdata_reg;
    logic [CW-1:0]      s2_cw_reg;
    logic [LW-1:0]      lin_next;
    logic [CWF-1:0]     cw_full;

    // stage 3: quotient estimate
    slot_ctl_t          s3_ctl_reg;
    logic [LW-1:0]      s3_lin_reg;
    logic [LW-1:0]      s3_q_reg;
    logic [TEXEL_W-1:0] s3_wdata_reg;
    logic [CW-1:0]      s3_cw_reg;
    logic [LW2-1:0]     q_full;

    // stage 4: quotient times store size
    slot_ctl_t          s4_ctl_reg;
    logic [LW-1:0]      s4_lin_reg;
    logic [LW-1:0]      s4_qm_reg;
    logic [TEXEL_W-1:0] s4_wdata_reg;
    logic [CW-1:0]      s4_cw_reg;
    logic [LW2-1:0]     qm_full;

    // stage 5: remainder with one correction
    slot_ctl_t          s5_ctl_reg;
    logic [AW-1:0]      s5_addr_reg;
    logic [TEXEL_W-1:0] s5_wdata_reg;
    logic [CW-1:0]      s5_cw_reg;
    logic [LW-1:0]      rem_raw;
    logic [LW-1:0]      rem_fix;

    assign lin_next = s1_ctl_reg.wr ? LW'(s1_waddr_reg)
                    : LW'(s1_cx_reg) + LW'(s1_cy_reg) * LW'(row_pitch);
    assign cw_full  = CWF'(s1_wx_reg) * CWF'(s1_wy_reg);
    assign q_full   = LW2'(s2_lin_reg) * LW2'(RECIP);
    assign qm_full  = LW2'(s3_q_reg) * LW2'(MOD);
    assign rem_raw  = s4_lin_reg - s4_qm_reg;
    assign rem_fix  = (rem_raw >= MOD) ? rem_raw - MOD : rem_raw;

    // slot control, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
            s5_ctl_reg <= '0;
        end else begin
            s1_ctl_reg <= in_ctl;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s3_ctl_reg;
            s5_ctl_reg <= s4_ctl_reg;
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        s1_cx_reg    <= in_cx;
        s1_cy_reg    <= in_cy;
        s1_waddr_reg <= in_waddr;
        s1_wdata_reg <= in_wdata;
        s1_wx_reg    <= in_wx;
        s1_wy_reg    <= in_wy;

        s2_lin_reg   <= lin_next;
        s2_wdata_reg <= s1_wdata_reg;
        s2_cw_reg    <= cw_full[CW-1:0];

        s3_lin_reg   <= s2_lin_reg;
        s3_q_reg     <= q_full[LW2-1:LW];
        s3_wdata_reg <= s2_wdata_reg;
        s3_cw_reg    <= s2_cw_reg;

        s4_lin_reg   <= s3_lin_reg;
        s4_qm_reg    <= qm_full[LW-1:0];
        s4_wdata_reg <= s3_wdata_reg;
        s4_cw_reg    <= s3_cw_reg;

        s5_addr_reg  <= rem_fix[AW-1:0];
        s5_wdata_reg <= s4_wdata_reg;
        s5_cw_reg    <= s4_cw_reg;
    end

    assign mem_ctl   = s5_ctl_reg;
    assign mem_addr  = s5_addr_reg;
    assign mem_wdata = s5_wdata_reg;
    assign mem_cw    = s5_cw_reg;

endmodule

>>> rtl/bts_blend.sv
// Blend unit: weights each corner texel, accumulates four corners, queues results.
// Depends on bts_pkg; fed by the texel memory read port of the top level.
module bts_blend import bts_pkg::*; #(
    parameter int WEIGHT_BITS = 8,
    localparam int CW = 2 * WEIGHT_BITS + 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  slot_ctl_t          in_ctl,
    input  logic [TEXEL_W-1:0] in_texel,
    input  logic [CW-1:0]      in_cw,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [OUT_W-1:0]   m_red_out,
    output logic [OUT_W-1:0]   m_green_out,
    output logic [OUT_W-1:0]   m_blue_out,
    output logic [OUT_W-1:0]   m_alpha_out
);
    localparam int PW        = CW + CH_W;
    localparam int OUT_SHIFT = 2 * WEIGHT_BITS - 8;
    localparam int ENTRY_W   = NUM_CH * OUT_W;

    slot_ctl_t            p_ctl_reg;
    logic [PW-1:0]        prod_reg [NUM_CH];
    logic [PW-1:0]        acc_reg  [NUM_CH];
    logic [PW-1:0]        sum      [NUM_CH];
    logic [ENTRY_W-1:0]   entry;
    logic                 push;
    logic                 pop;

    logic [ENTRY_W-1:0]    fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;

    // per-channel texel times corner weight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_ctl_reg <= '0;
        end else begin
            p_ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            prod_reg[ch] <= PW'(in_texel[ch*CH_W +: CH_W]) * PW'(in_cw);
        end
    end

    // accumulate, restarting on the first corner
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            sum[ch] = (p_ctl_reg.first ? PW'(0) : acc_reg[ch]) + prod_reg[ch];
        end
    end

    always_ff @(posedge aclk) begin
        if (p_ctl_reg.valid) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                acc_reg[ch] <= sum[ch];
            end
        end
    end

    // truncate to 8.8 and pack for the queue
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            entry[ch*OUT_W +: OUT_W] = sum[ch][OUT_SHIFT +: OUT_W];
        end
    end

    assign push = p_ctl_reg.valid & p_ctl_reg.last;
    assign pop  = m_valid & m_ready;

    // result queue
    assign wr_ptr_next = push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
    assign rd_ptr_next = pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
    assign cnt_next    = cnt_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= entry;
        end
    end

    assign m_valid     = (cnt_reg != '0);
    assign m_red_out   = fifo_mem[rd_ptr_reg][0*OUT_W +: OUT_W];
    assign m_green_out = fifo_mem[rd_ptr_reg][1*OUT_W +: OUT_W];
    assign m_blue_out  = fifo_mem[rd_ptr_reg][2*OUT_W +: OUT_W];
    assign m_alpha_out = fifo_mem[rd_ptr_reg][3*OUT_W +: OUT_W];

    // checks
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (cnt_reg != FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

    a_corners_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_ctl.valid && !in_ctl.first) |-> $past(in_ctl.valid && !in_ctl.last))
        else $error("corner read without its predecessor");

    a_push_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> m_valid)
        else $error("pushed result not visible");

endmodule

>>> rtl/bilinear_texture_sampler_core.sv
// Bilinear texture sampler: a write beat stores one RGBA8 texel, a sample beat
// reads the four neighbours of (u, v) from the single-ported texel memory and
// returns each channel blended in 8.8 fixed point. A write needs one memory
// access and a sample four (one read per corner), so a new beat waits while a
// sample's corners are issued, and writes are taken one per cycle otherwise;
// beats move through an in-order pipeline, so a sample always sees every earlier
// write. A result waits in a four-entry queue, so the input keeps flowing while
// the output stalls until four results are outstanding. The texel memory is not
// cleared: read only texels that were written. The user must write configuration
// only while the block is idle; the block does not enforce this.
// Depends on bts_pkg, bts_coord_split, bts_addr_unit and bts_blend.
module bilinear_texture_sampler_core import bts_pkg::*; #(
    parameter int STORE_WORDS     = 65536,
    parameter int COORD_FRAC_BITS = 16,
    parameter int WEIGHT_BITS     = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SIZE_W-1:0]     cfg_data,
    // item input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [ADDR_IN_W-1:0]  s_texel_addr,
    input  logic [TEXEL_W-1:0]    s_texel_rgba,
    input  logic [COORD_IN_W-1:0] s_u_frac,
    input  logic [COORD_IN_W-1:0] s_v_frac,
    // result output
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [OUT_W-1:0]      m_red_out,
    output logic [OUT_W-1:0]      m_green_out,
    output logic [OUT_W-1:0]      m_blue_out,
    output logic [OUT_W-1:0]      m_alpha_out
);
    localparam int AW  = $clog2(STORE_WORDS);
    localparam int CW  = 2 * WEIGHT_BITS + 1;
    localparam int WT1 = WEIGHT_BITS + 1;
    localparam logic [WEIGHT_BITS:0] WT_ONE = WT1'(1) << WEIGHT_BITS;

    // configuration registers
    logic [SIZE_W-1:0] tex_width_reg, tex_height_reg, row_pitch_reg;
    logic [SIZE_W-1:0] w_eff, h_eff;

    // input register
    logic                  a_valid_reg;
    logic                  a_action_reg;
    logic [ADDR_IN_W-1:0]  a_addr_reg;
    logic [TEXEL_W-1:0]    a_rgba_reg;
    logic [COORD_IN_W-1:0] a_u_reg, a_v_reg;

    // corner sequencer
    logic                    b_valid_reg;
    logic                    b_wr_reg;
    logic [1:0]              b_cnt_reg;
    logic signed [IDX_W-1:0] b_ix_reg, b_iy_reg;
    logic [WEIGHT_BITS-1:0]  b_wx_reg, b_wy_reg;
    logic [ADDR_IN_W-1:0]    b_addr_reg;
    logic [TEXEL_W-1:0]      b_rgba_reg;

    logic signed [IDX_W-1:0] split_ix, split_iy;
    logic [WEIGHT_BITS-1:0]  split_wx, split_wy;

    logic b_done, b_free, a_go, take, give;
    logic [FIFO_CNT_W-1:0] used_reg, used_next;

    // corner request
    slot_ctl_t               req_ctl;
    logic signed [IDX_W-1:0] x_pos, y_pos;
    logic [SIZE_W-1:0]       req_cx, req_cy;
    logic [WEIGHT_BITS:0]    req_wx, req_wy;

    // memory port and read side
    slot_ctl_t          mem_ctl;
    logic [AW-1:0]      mem_addr;
    logic [TEXEL_W-1:0] mem_wdata;
    logic [CW-1:0]      mem_cw;
    logic [TEXEL_W-1:0] store_mem [STORE_WORDS];
    logic [TEXEL_W-1:0] rd_data_reg;
    slot_ctl_t          rd_ctl_reg;
    logic [CW-1:0]      rd_cw_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tex_width_reg  <= SIZE_RESET;
            tex_height_reg <= SIZE_RESET;
            row_pitch_reg  <= SIZE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TEX_WIDTH:  tex_width_reg  <= cfg_data;
                CFG_TEX_HEIGHT: tex_height_reg <= cfg_data;
                CFG_ROW_PITCH:  row_pitch_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // a zero size acts as one
    assign w_eff = (tex_width_reg == '0) ? SIZE_W'(1) : tex_width_reg;
    assign h_eff = (tex_height_reg == '0) ? SIZE_W'(1) : tex_height_reg;

    // handshake and sample credits
    assign b_done  = b_valid_reg & (b_wr_reg | (b_cnt_reg == CORNER_LAST));
    assign b_free  = ~b_valid_reg | b_done;
    assign a_go    = a_valid_reg & b_free
                   & ((a_action_reg == ACT_WRITE) | (used_reg < FIFO_CNT_W'(FIFO_DEPTH)));
    assign s_ready = ~a_valid_reg | a_go;
    assign take    = a_go & (a_action_reg == ACT_SAMPLE);
    assign give    = m_valid & m_ready;
    assign used_next = used_reg + FIFO_CNT_W'(take) - FIFO_CNT_W'(give);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            used_reg    <= '0;
        end else begin
            used_reg <= used_next;
            if (s_valid && s_ready) begin
                a_valid_reg <= 1'b1;
            end else if (a_go) begin
                a_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_action_reg <= s_action;
            a_addr_reg   <= s_texel_addr;
            a_rgba_reg   <= s_texel_rgba;
            a_u_reg      <= s_u_frac;
            a_v_reg      <= s_v_frac;
        end
    end

    // coordinate split for the next sample
    bts_coord_split #(
        .FRAC_BITS (COORD_FRAC_BITS),
        .WT_BITS   (WEIGHT_BITS)
    ) u_split_u (
        .frac (COORD_FRAC_BITS'(a_u_reg)),
        .size (w_eff),
        .idx  (split_ix),
        .wt   (split_wx)
    );

    bts_coord_split #(
        .FRAC_BITS (COORD_FRAC_BITS),
        .WT_BITS   (WEIGHT_BITS)
    ) u_split_v (
        .frac (COORD_FRAC_BITS'(a_v_reg)),
        .size (h_eff),
        .idx  (split_iy),
        .wt   (split_wy)
    );

    // sequencer steps one corner per cycle, a write takes one slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            b_cnt_reg   <= '0;
        end else if (a_go) begin
            b_valid_reg <= 1'b1;
            b_cnt_reg   <= '0;
        end else if (b_done) begin
            b_valid_reg <= 1'b0;
        end else if (b_valid_reg) begin
            b_cnt_reg <= b_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_go) begin
            b_wr_reg   <= (a_action_reg == ACT_WRITE);
            b_ix_reg   <= split_ix;
            b_iy_reg   <= split_iy;
            b_wx_reg   <= split_wx;
            b_wy_reg   <= split_wy;
            b_addr_reg <= a_addr_reg;
            b_rgba_reg <= a_rgba_reg;
        end
    end

    // clamp corner coordinates to the texture edge
    assign x_pos = b_ix_reg + $signed({{(IDX_W-1){1'b0}}, b_cnt_reg[0]});
    assign y_pos = b_iy_reg + $signed({{(IDX_W-1){1'b0}}, b_cnt_reg[1]});

    always_comb begin
        if (x_pos < 0) begin
            req_cx = '0;
        end else if (x_pos > $signed({1'b0, w_eff - SIZE_W'(1)})) begin
            req_cx = w_eff - SIZE_W'(1);
        end else begin
            req_cx = x_pos[SIZE_W-1:0];
        end
        if (y_pos < 0) begin
            req_cy = '0;
        end else if (y_pos > $signed({1'b0, h_eff - SIZE_W'(1)})) begin
            req_cy = h_eff - SIZE_W'(1);
        end else begin
            req_cy = y_pos[SIZE_W-1:0];
        end
    end

    // per-corner weight factors
    assign req_wx = b_cnt_reg[0] ? {1'b0, b_wx_reg} : WT_ONE - {1'b0, b_wx_reg};
    assign req_wy = b_cnt_reg[1] ? {1'b0, b_wy_reg} : WT_ONE - {1'b0, b_wy_reg};

    assign req_ctl.valid = b_valid_reg;
    assign req_ctl.wr    = b_wr_reg;
    assign req_ctl.first = (b_cnt_reg == 2'd0);
    assign req_ctl.last  = (b_cnt_reg == CORNER_LAST);

    bts_addr_unit #(
        .STORE_WORDS (STORE_WORDS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_addr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (req_ctl),
        .in_cx     (req_cx),
        .in_cy     (req_cy),
        .in_waddr  (b_addr_reg),
        .in_wdata  (b_rgba_reg),
        .in_wx     (req_wx),
        .in_wy     (req_wy),
        .row_pitch (row_pitch_reg),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_cw    (mem_cw)
    );

    // texel memory, one access per cycle in item order
    always_ff @(posedge aclk) begin
        if (mem_ctl.valid) begin
            if (mem_ctl.wr) begin
                store_mem[mem_addr] <= mem_wdata;
            end else begin
                rd_data_reg <= store_mem[mem_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ctl_reg <= '0;
        end else begin
            rd_ctl_reg.valid <= mem_ctl.valid & ~mem_ctl.wr;
            rd_ctl_reg.wr    <= 1'b0;
            rd_ctl_reg.first <= mem_ctl.first;
            rd_ctl_reg.last  <= mem_ctl.last;
        end
    end

    always_ff @(posedge aclk) begin
        rd_cw_reg <= mem_cw;
    end

    bts_blend #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_blend (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_ctl      (rd_ctl_reg),
        .in_texel    (rd_data_reg),
        .in_cw       (rd_cw_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_alpha_out (m_alpha_out)
    );

    // checks
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("outstanding samples exceed queue depth");

    a_corner_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !b_wr_reg && (b_cnt_reg != CORNER_LAST))
            |=> (b_valid_reg && (b_cnt_reg == $past(b_cnt_reg) + 2'd1)))
        else $error("corner sequence broken");

    a_result_has_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (used_reg != '0))
        else $error("result without outstanding sample");

endmodule

>>> dv/bts_sample_checker.sv
// Result checker for the bilinear texture sampler: mirrors the texel memory and the
// size registers, predicts each filtered sample and compares the result beats.
// Depends on bts_pkg.
module bts_sample_checker import bts_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SIZE_W-1:0]     cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_action,
    input  logic [ADDR_IN_W-1:0]  s_texel_addr,
    input  logic [TEXEL_W-1:0]    s_texel_rgba,
    input  logic [COORD_IN_W-1:0] s_u_frac,
    input  logic [COORD_IN_W-1:0] s_v_frac,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [OUT_W-1:0]      m_red_out,
    input  logic [OUT_W-1:0]      m_green_out,
    input  logic [OUT_W-1:0]      m_blue_out,
    input  logic [OUT_W-1:0]      m_alpha_out,
    output int                    fail_count,
    output int                    pending_count
);

    localparam int     STORE_DEPTH = 65536;
    localparam int     FRAC_BITS   = COORD_IN_W;
    localparam int     WGT_BITS    = 8;
    localparam int     WGT_ONE     = 1 << WGT_BITS;
    localparam int     OUT_SHIFT   = 2 * WGT_BITS - CH_W;
    localparam longint HALF_TEXEL  = longint'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic [OUT_W-1:0] alpha;
        logic [OUT_W-1:0] blue;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] red;
    } filtered_texel_t;

    logic [TEXEL_W-1:0] texel_mirror [STORE_DEPTH];
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [SIZE_W-1:0]  pitch_reg;
    filtered_texel_t    expected_texels [$];
    filtered_texel_t    got;
    filtered_texel_t    want;

    // texel-space position f*size - half: clamped neighbour pair and blend weight
    function automatic void split_axis(input logic [COORD_IN_W-1:0] f, input int size,
                                       output int lo, output int hi, output int wt);
        longint t;
        int     base;
        t    = longint'(f) * size + HALF_TEXEL;
        base = int'(t >> FRAC_BITS) - 1;
        wt   = int'(t[FRAC_BITS-1:0]) >> (FRAC_BITS - WGT_BITS);
        lo   = (base < 0) ? 0 : ((base > size - 1) ? size - 1 : base);
        hi   = (base + 1 > size - 1) ? size - 1 : base + 1;
    endfunction

    function automatic int texel_index(input int x, input int y);
        return (x + y * int'(pitch_reg)) % STORE_DEPTH;
    endfunction

    // one 8-bit channel of the four neighbours, blended and truncated to 8.8
    function automatic logic [OUT_W-1:0] blend_channel(input int ch,
            input logic [TEXEL_W-1:0] nw, ne, sw, se, input int wx, input int wy);
        int upper_mix;
        int lower_mix;
        int sum;
        upper_mix = int'(nw[ch*CH_W +: CH_W]) * (WGT_ONE - wx)
                  + int'(ne[ch*CH_W +: CH_W]) * wx;
        lower_mix = int'(sw[ch*CH_W +: CH_W]) * (WGT_ONE - wx)
                  + int'(se[ch*CH_W +: CH_W]) * wx;
        sum = upper_mix * (WGT_ONE - wy) + lower_mix * wy;
        return OUT_W'(sum >> OUT_SHIFT);
    endfunction

    function automatic filtered_texel_t bilinear_filter(input logic [COORD_IN_W-1:0] u,
                                                        input logic [COORD_IN_W-1:0] v);
        int                 w, h, x0, x1, y0, y1, wx, wy;
        logic [TEXEL_W-1:0] nw, ne, sw, se;
        filtered_texel_t    res;
        // a zero size behaves as one texel
        w = (width_reg == '0) ? 1 : int'(width_reg);
        h = (height_reg == '0) ? 1 : int'(height_reg);
        split_axis(u, w, x0, x1, wx);
        split_axis(v, h, y0, y1, wy);
        nw = texel_mirror[texel_index(x0, y0)];
        ne = texel_mirror[texel_index(x1, y0)];
        sw = texel_mirror[texel_index(x0, y1)];
        se = texel_mirror[texel_index(x1, y1)];
        res.red   = blend_channel(0, nw, ne, sw, se, wx, wy);
        res.green = blend_channel(1, nw, ne, sw, se, wx, wy);
        res.blue  = blend_channel(2, nw, ne, sw, se, wx, wy);
        res.alpha = blend_channel(3, nw, ne, sw, se, wx, wy);
        return res;
    endfunction

    function automatic void check_field(input string field, input logic [OUT_W-1:0] want_v,
                                        input logic [OUT_W-1:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %h, got %h", $time, field, want_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = SIZE_RESET;
            height_reg = SIZE_RESET;
            pitch_reg  = SIZE_RESET;
            expected_texels.delete();
        end else begin
            // register writes, only ever issued while idle
            if (cfg_we) begin
                case (cfg_index)
                    CFG_TEX_WIDTH:  width_reg  = cfg_data;
                    CFG_TEX_HEIGHT: height_reg = cfg_data;
                    CFG_ROW_PITCH:  pitch_reg  = cfg_data;
                    default: ;
                endcase
            end
            // result beat against the oldest prediction
            if (m_valid && m_ready) begin
                got = {m_alpha_out, m_blue_out, m_green_out, m_red_out};
                if (expected_texels.size() == 0) begin
                    $display("%0t: result beat, expected none, got %h", $time, got);
                    fail_count++;
                end else begin
                    want = expected_texels.pop_front();
                    check_field("red_out", want.red, got.red);
                    check_field("green_out", want.green, got.green);
                    check_field("blue_out", want.blue, got.blue);
                    check_field("alpha_out", want.alpha, got.alpha);
                end
            end
            // input beat: writes update the mirror, samples queue a prediction
            if (s_valid && s_ready) begin
                if (s_action == ACT_WRITE) begin
                    texel_mirror[s_texel_addr] = s_texel_rgba;
                end else begin
                    expected_texels.push_back(bilinear_filter(s_u_frac, s_v_frac));
                end
            end
        end
        pending_count <= expected_texels.size();
    end

endmodule

>>> dv/tb_bilinear_texture_sampler_core.sv
// Testbench top for bilinear_texture_sampler_core: clock, reset, size settings and
// beats on both channels; bts_sample_checker does the prediction and comparison.
// Depends on bts_pkg, bilinear_texture_sampler_core and bts_sample_checker.
module tb_bilinear_texture_sampler_core;
    import bts_pkg::*;

    localparam int SETTLE_CYCLES   = 32;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_BEATS     = 75;
    localparam int STORE_DEPTH     = 65536;
    localparam longint HALF_TEXEL  = longint'(1) << (COORD_IN_W - 1);
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_TEX_WIDTH;
    logic [SIZE_W-1:0]     cfg_data     = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic                  s_action     = ACT_WRITE;
    logic [ADDR_IN_W-1:0]  s_texel_addr = '0;
    logic [TEXEL_W-1:0]    s_texel_rgba = '0;
    logic [COORD_IN_W-1:0] s_u_frac     = '0;
    logic [COORD_IN_W-1:0] s_v_frac     = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [OUT_W-1:0]      m_red_out;
    logic [OUT_W-1:0]      m_green_out;
    logic [OUT_W-1:0]      m_blue_out;
    logic [OUT_W-1:0]      m_alpha_out;

    int fail_count;
    int pending_count;

    // current sizes, for steering stimulus away from unwritten texels
    int cur_w = int'(SIZE_RESET);
    int cur_h = int'(SIZE_RESET);
    int cur_p = int'(SIZE_RESET);
    bit texel_written [STORE_DEPTH];
    bit steady_flow;
    bit rx_steady;
    bit hold_off_req;
    // input beats accepted so far, fill writes included
    int beats_sent = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    bilinear_texture_sampler_core u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_texel_addr (s_texel_addr),
        .s_texel_rgba (s_texel_rgba),
        .s_u_frac     (s_u_frac),
        .s_v_frac     (s_v_frac),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_out    (m_red_out),
        .m_green_out  (m_green_out),
        .m_blue_out   (m_blue_out),
        .m_alpha_out  (m_alpha_out)
    );

    bts_sample_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_texel_addr  (s_texel_addr),
        .s_texel_rgba  (s_texel_rgba),
        .s_u_frac      (s_u_frac),
        .s_v_frac      (s_v_frac),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_out     (m_red_out),
        .m_green_out   (m_green_out),
        .m_blue_out    (m_blue_out),
        .m_alpha_out   (m_alpha_out),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [COORD_IN_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 16'h8000;
            default: return COORD_IN_W'($urandom);
        endcase
    endfunction

    // clamped neighbour pair along one axis
    function automatic void texel_span(input logic [COORD_IN_W-1:0] f, input int size,
                                       output int lo, output int hi);
        int base;
        base = int'((longint'(f) * size + HALF_TEXEL) >> COORD_IN_W) - 1;
        lo   = (base < 0) ? 0 : ((base > size - 1) ? size - 1 : base);
        hi   = (base + 1 > size - 1) ? size - 1 : base + 1;
    endfunction

    // offer one beat and hold it until accepted
    task automatic send_beat(input logic act, input logic [ADDR_IN_W-1:0] addr,
                             input logic [TEXEL_W-1:0] rgba,
                             input logic [COORD_IN_W-1:0] u, input logic [COORD_IN_W-1:0] v);
        int gap;
        gap = steady_flow ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_texel_addr <= addr;
        s_texel_rgba <= rgba;
        s_u_frac     <= u;
        s_v_frac     <= v;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic put_texel(input logic [ADDR_IN_W-1:0] addr, input logic [TEXEL_W-1:0] rgba);
        texel_written[addr] = 1'b1;
        send_beat(ACT_WRITE, addr, rgba, COORD_IN_W'($urandom), COORD_IN_W'($urandom));
    endtask

    // fill any unwritten neighbour first, then the sample beat
    task automatic sample_at(input logic [COORD_IN_W-1:0] u, input logic [COORD_IN_W-1:0] v);
        int                   xs [2];
        int                   ys [2];
        logic [ADDR_IN_W-1:0] addr;
        texel_span(u, (cur_w == 0) ? 1 : cur_w, xs[0], xs[1]);
        texel_span(v, (cur_h == 0) ? 1 : cur_h, ys[0], ys[1]);
        foreach (ys[j]) begin
            foreach (xs[i]) begin
                addr = ADDR_IN_W'((xs[i] + ys[j] * cur_p) % STORE_DEPTH);
                if (!texel_written[addr]) put_texel(addr, $urandom);
            end
        end
        send_beat(ACT_SAMPLE, ADDR_IN_W'($urandom), $urandom, u, v);
    endtask

    // wait out every expected result plus any write still in flight
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_config(input int w, input int h, input int p);
        cur_w = w;
        cur_h = h;
        cur_p = p;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TEX_WIDTH;
        cfg_data  <= SIZE_W'(w);
        @(posedge aclk);
        cfg_index <= CFG_TEX_HEIGHT;
        cfg_data  <= SIZE_W'(h);
        @(posedge aclk);
        cfg_index <= CFG_ROW_PITCH;
        cfg_data  <= SIZE_W'(p);
        @(posedge aclk);
        cfg_index <= CFG_SPARE;
        cfg_data  <= SIZE_W'($urandom);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // one size setting with a random mix of texel writes and samples,
    // fill writes counted against the beat budget
    task automatic run_phase(input int w, input int h, input int p, input int beats,
                             input int write_pct, input bit no_idle, input bit hold_rx);
        int eff_w;
        int eff_h;
        int stop_at;
        drain_results();
        apply_config(w, h, p);
        eff_w        = (w == 0) ? 1 : w;
        eff_h        = (h == 0) ? 1 : h;
        steady_flow  = no_idle;
        rx_steady    = no_idle;
        hold_off_req = hold_rx;
        stop_at      = beats_sent + beats;
        while (beats_sent < stop_at) begin
            if ($urandom_range(0, 99) < write_pct) begin
                // mostly inside the texture footprint so samples pick them up
                if ($urandom_range(0, 3) != 0) begin
                    put_texel(ADDR_IN_W'((int'($urandom_range(0, eff_w - 1))
                              + int'($urandom_range(0, eff_h - 1)) * p) % STORE_DEPTH),
                              $urandom);
                end else begin
                    put_texel(ADDR_IN_W'($urandom), $urandom);
                end
            end else begin
                sample_at(pick_coord(), pick_coord());
            end
        end
    endtask

    // result side: random stalls, a long hold-off on request
    initial begin
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset sizes: address extremes, corners, centers and both weight ends
        put_texel('0, 32'h0000_0000);
        put_texel('1, 32'hFFFF_FFFF);
        put_texel(16'h00FF, 32'hA5C3_3C5A);
        put_texel(16'hFF00, 32'h5A3C_C3A5);
        sample_at(16'h0000, 16'h0000);
        sample_at(16'hFFFF, 16'hFFFF);
        sample_at(16'h0000, 16'hFFFF);
        sample_at(16'hFFFF, 16'h0000);
        sample_at(16'h8000, 16'h8000);
        sample_at(16'h0080, 16'h0080);
        sample_at(16'h007F, 16'h007F);

        // zero sizes and zero pitch all collapse onto one texel
        drain_results();
        apply_config(0, 0, 0);
        sample_at(pick_coord(), pick_coord());
        sample_at(16'hFFFF, 16'h1234);

        // sizes above the nominal range
        drain_results();
        apply_config(8191, 8191, 8191);
        sample_at(16'hFFFF, 16'hFFFF);
        sample_at(16'h0000, 16'h8000);

        // single row, zero pitch
        drain_results();
        apply_config(4096, 1, 0);
        sample_at(16'h4321, 16'hFFFF);

        // random phases over several size settings
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0:  run_phase(4, 4, 4, PHASE_BEATS, 15, 1'b1, 1'b1);
                1:  run_phase(1, 1, 1, PHASE_BEATS, 30, 1'b1, 1'b0);
                2:  run_phase(0, 0, 0, PHASE_BEATS, 30, 1'b0, 1'b0);
                3:  run_phase(3, 5, 7, PHASE_BEATS, 35, 1'b0, 1'b0);
                4:  run_phase(16, 8, 3, PHASE_BEATS, 35, 1'b0, 1'b0);
                5:  run_phase(4096, 4096, 4096, PHASE_BEATS, 20, 1'b0, 1'b0);
                6:  run_phase(8191, 8191, 8191, PHASE_BEATS, 20, 1'b0, 1'b0);
                7:  run_phase(4096, 1, 0, PHASE_BEATS, 25, 1'b0, 1'b0);
                11: run_phase($urandom_range(0, 8191), $urandom_range(0, 8191),
                              $urandom_range(0, 8191), PHASE_BEATS, 25, 1'b0, 1'b0);
                default: run_phase($urandom_range(1, 64), $urandom_range(1, 64),
                                   $urandom_range(0, 80), PHASE_BEATS, 35, 1'b0, 1'b0);
            endcase
        end

        drain_results();
        if (fail_count == 0) begin
            $display("tb_bilinear_texture_sampler_core: done, clean");
        end else begin
            $display("tb_bilinear_texture_sampler_core: done, errors");
        end
        $finish;
    end

    // hang guard
    initial begin
        #20_000_000;
        $display("tb_bilinear_texture_sampler_core: done, errors");
        $finish;
    end

endmodule
